### rtl/core/rlti_pkg.sv
// shared types, character codes and digit helpers for the radix literal parser
package rlti_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SizeW    = 64;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned DigitW   = 5;

  localparam logic [CharW-1:0] ChUnder  = 8'h5F;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowF   = 8'h66;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpF    = 8'h46;
  localparam logic [CharW-1:0] ChLowX   = 8'h78;
  localparam logic [CharW-1:0] ChUpX    = 8'h58;
  localparam logic [CharW-1:0] ChLowB   = 8'h62;
  localparam logic [CharW-1:0] ChUpB    = 8'h42;
  localparam logic [CharW-1:0] ChLowO   = 8'h6F;
  localparam logic [CharW-1:0] ChUpO    = 8'h4F;
  localparam logic [CharW-1:0] ChUpU    = 8'h55;
  localparam logic [CharW-1:0] ChUpL    = 8'h4C;
  localparam logic [CharW-1:0] ChUpS    = 8'h53;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5A;

  localparam logic [DigitW-1:0] DigitNone = 5'd31;
  localparam logic [DigitW-1:0] HexTen    = 5'd10;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2,
    RADIX_OCT = 2'd3
  } radix_e;

  typedef struct packed {
    logic open;
    logic nonempty;
    logic ovf;
    logic junk;
  } run_flags_t;

  localparam run_flags_t RunReset = '{open: 1'b1, nonempty: 1'b0, ovf: 1'b0, junk: 1'b0};
  localparam run_flags_t RunZero  = '{open: 1'b1, nonempty: 1'b1, ovf: 1'b0, junk: 1'b0};

  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = DigitNone;
    priority if (c >= ChZero && c <= ChNine) begin
      d = DigitW'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      d = DigitW'(c - ChLowA) + HexTen;
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = DigitW'(c - ChUpA) + HexTen;
    end else begin
      d = DigitNone;
    end
    return d;
  endfunction

  function automatic logic [DigitW-1:0] base_of(input radix_e r);
    logic [DigitW-1:0] b;
    unique case (r)
      RADIX_HEX: b = 5'd16;
      RADIX_BIN: b = 5'd2;
      RADIX_OCT: b = 5'd8;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

  function automatic logic is_suffix(input logic [CharW-1:0] c);
    return (c == ChUpU) || (c == ChUpL) || (c == ChUpS) || (c == ChUpB) || (c == ChUpZ);
  endfunction

endpackage

### rtl/core/radix_literal_to_integer_core.sv
// number literal parser: radix prefix, underscores, suffix stripping, one char per cycle unless stalled
//
//   channel  dir  fields (lowest bit first)            meaning
//   s_axis   in   tdata: char_code[7:0]; tlast: last   one literal character per transfer
//   m_axis   out  tdata: size_value[63:0], error[64]   one result per literal, on its last char
//
// one char per cycle unless stalled; result valid in the cycle after the last char
// the run state and a speculative copy with a held suffix 'B' replayed are both
// kept, so each character costs one multiply-add, two digit steps side by side
// reset spares the result data; a held result stalls input only while m_axis_tready is low
module radix_literal_to_integer_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rlti_pkg::InDataW-1:0]   s_axis_tdata,   // char_code[7:0]
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rlti_pkg::OutDataW-1:0]  m_axis_tdata    // size_value[63:0], parse_error[64]
);
  import rlti_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhZero = 2'd1;
  localparam logic [1:0] PhBody = 2'd2;

  logic [1:0]             phase_q, phase_d;
  radix_e                 radix_q, radix_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  run_flags_t             flg_q, flg_d;
  logic [VALUE_WIDTH-1:0] spec_acc_q, spec_acc_d;
  run_flags_t             spec_flg_q, spec_flg_d;
  logic                   pend_q, pend_d;
  logic                   other_q, other_d;

  logic                   out_valid_q;
  logic [SizeW-1:0]       out_size_q, out_size_d;
  logic                   out_err_q, out_err_d;

  logic [CharW-1:0]       c;
  logic                   in_fire;
  logic                   is_prefix;
  radix_e                 prefix_radix;
  run_flags_t             cur_flg;
  logic [VALUE_WIDTH-1:0] src_acc;
  run_flags_t             src_flg;
  logic [VALUE_WIDTH-1:0] a_acc, b_acc;
  run_flags_t             a_flg, b_flg;
  logic                   bad;

  assign c             = s_axis_tdata[CharW-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cur_flg = (phase_q == PhZero) ? RunZero : flg_q;
  assign src_acc = pend_q ? spec_acc_q : acc_q;
  assign src_flg = pend_q ? spec_flg_q : cur_flg;

  always_comb begin
    is_prefix    = 1'b1;
    prefix_radix = RADIX_DEC;
    priority if (c == ChLowX || c == ChUpX) begin
      prefix_radix = RADIX_HEX;
    end else if (c == ChLowB || c == ChUpB) begin
      prefix_radix = RADIX_BIN;
    end else if (c == ChLowO || c == ChUpO) begin
      prefix_radix = RADIX_OCT;
    end else begin
      is_prefix = 1'b0;
    end
  end

  // kept character applied to the run
  rlti_digit_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step_char (
    .acc_i   (src_acc),
    .flags_i (src_flg),
    .radix_i (radix_q),
    .char_i  (c),
    .acc_o   (a_acc),
    .flags_o (a_flg)
  );

  // held suffix 'B' replayed into the speculative copy
  rlti_digit_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step_b (
    .acc_i   (src_acc),
    .flags_i (src_flg),
    .radix_i (radix_q),
    .char_i  (ChUpB),
    .acc_o   (b_acc),
    .flags_o (b_flg)
  );

  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    acc_d      = acc_q;
    flg_d      = flg_q;
    spec_acc_d = spec_acc_q;
    spec_flg_d = spec_flg_q;
    pend_d     = pend_q;
    other_d    = other_q;
    if (c != ChUnder) begin
      priority if (phase_q == PhIdle && c == ChZero) begin
        phase_d = PhZero;
      end else if (phase_q == PhZero && is_prefix) begin
        phase_d = PhBody;
        radix_d = prefix_radix;
      end else begin
        phase_d = PhBody;
        if (is_suffix(c)) begin
          flg_d  = cur_flg;
          pend_d = 1'b1;
          if (c == ChUpB && !other_q) begin
            spec_acc_d = b_acc;
            spec_flg_d = b_flg;
          end else begin
            spec_acc_d      = src_acc;
            spec_flg_d      = src_flg;
            spec_flg_d.open = 1'b0;
            spec_flg_d.junk = 1'b1;
            other_d         = 1'b1;
          end
        end else begin
          acc_d   = a_acc;
          flg_d   = a_flg;
          pend_d  = 1'b0;
          other_d = 1'b0;
        end
      end
    end
  end

  // held '0' at the end counts as one digit of value zero
  assign bad        = !(flg_d.nonempty || (phase_d == PhZero)) || flg_d.ovf;
  assign out_size_d = bad ? '0 : SizeW'(acc_d);
  assign out_err_d  = bad || flg_d.junk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      radix_q    <= RADIX_DEC;
      acc_q      <= '0;
      flg_q      <= RunReset;
      spec_acc_q <= '0;
      spec_flg_q <= RunReset;
      pend_q     <= 1'b0;
      other_q    <= 1'b0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        phase_q    <= PhIdle;
        radix_q    <= RADIX_DEC;
        acc_q      <= '0;
        flg_q      <= RunReset;
        spec_acc_q <= '0;
        spec_flg_q <= RunReset;
        pend_q     <= 1'b0;
        other_q    <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        radix_q    <= radix_d;
        acc_q      <= acc_d;
        flg_q      <= flg_d;
        spec_acc_q <= spec_acc_d;
        spec_flg_q <= spec_flg_d;
        pend_q     <= pend_d;
        other_q    <= other_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      out_size_q <= out_size_d;
      out_err_q  <= out_err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - SizeW - 1){1'b0}}, out_err_q, out_size_q};

endmodule

### rtl/core/rlti_digit_step.sv
// one character applied to the digit run: multiply-add with overflow detect
module rlti_digit_step #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  rlti_pkg::run_flags_t   flags_i,
  input  rlti_pkg::radix_e       radix_i,
  input  logic [7:0]             char_i,
  output logic [VALUE_WIDTH-1:0] acc_o,
  output rlti_pkg::run_flags_t   flags_o
);
  import rlti_pkg::*;

  logic [DigitW-1:0]        digit;
  logic [DigitW-1:0]        base;
  logic [VALUE_WIDTH+4:0]   prod;
  logic                     too_big;

  assign digit   = digit_of(char_i);
  assign base    = base_of(radix_i);
  assign prod    = ({5'b0, acc_i} * {{VALUE_WIDTH{1'b0}}, base}) +
                   {{VALUE_WIDTH{1'b0}}, digit};
  assign too_big = |prod[VALUE_WIDTH+4:VALUE_WIDTH];

  always_comb begin
    acc_o   = acc_i;
    flags_o = flags_i;
    if (flags_i.open && (digit < base)) begin
      if (!flags_i.ovf) begin
        if (too_big) begin
          flags_o.ovf = 1'b1;
        end else begin
          acc_o = prod[VALUE_WIDTH-1:0];
        end
      end
      flags_o.nonempty = 1'b1;
    end else begin
      flags_o.open = 1'b0;
      flags_o.junk = 1'b1;
    end
  end

endmodule
